### hdl/hcy_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcy_pkg
// Types, widths and constants shared by the HCY to RGB conversion pipeline.
// ----------------------------------------------------------------------------
package hcy_pkg;

   localparam int CHANNEL_BITS  = 12;
   localparam int LEVEL_MAX     = (1 << CHANNEL_BITS) - 1;
   localparam int HUE_BITS      = CHANNEL_BITS + 3;
   localparam int SEXT_BITS     = 3;
   localparam int LEVEL_S_BITS  = CHANNEL_BITS + 1;
   localparam int WEIGHT_BITS   = 13;
   localparam int WEIGHT_SHIFT  = 12;
   localparam int PROD_BITS     = LEVEL_S_BITS + WEIGHT_BITS;
   localparam int SUM_BITS      = PROD_BITS + 2;
   localparam int OFS_BITS      = CHANNEL_BITS + 3;
   localparam int MIX_BITS      = CHANNEL_BITS + 4;

   localparam logic signed [WEIGHT_BITS-1:0] W_RED   = WEIGHT_BITS'(1229);
   localparam logic signed [WEIGHT_BITS-1:0] W_GREEN = WEIGHT_BITS'(2417);
   localparam logic signed [WEIGHT_BITS-1:0] W_BLUE  = WEIGHT_BITS'(451);

   localparam logic [SEXT_BITS-1:0] SEXT_RED_YEL   = SEXT_BITS'(0);
   localparam logic [SEXT_BITS-1:0] SEXT_YEL_GRN   = SEXT_BITS'(1);
   localparam logic [SEXT_BITS-1:0] SEXT_GRN_CYN   = SEXT_BITS'(2);
   localparam logic [SEXT_BITS-1:0] SEXT_CYN_BLU   = SEXT_BITS'(3);
   localparam logic [SEXT_BITS-1:0] SEXT_BLU_MAG   = SEXT_BITS'(4);
   localparam logic [SEXT_BITS-1:0] SEXT_MAG_RED   = SEXT_BITS'(5);

   typedef struct packed {
      logic [HUE_BITS-1:0]     hue;
      logic [CHANNEL_BITS-1:0] chroma;
      logic [CHANNEL_BITS-1:0] luma;
   } req_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } rsp_type;

   typedef struct packed {
      logic                           valid;
      logic [SEXT_BITS-1:0]           sextant;
      logic [CHANNEL_BITS-1:0]        chroma;
      logic [CHANNEL_BITS-1:0]        luma;
      logic signed [LEVEL_S_BITS-1:0] x;
   } tri_type;

   typedef struct packed {
      logic                           valid;
      logic signed [LEVEL_S_BITS-1:0] r;
      logic signed [LEVEL_S_BITS-1:0] g;
      logic signed [LEVEL_S_BITS-1:0] b;
      logic signed [OFS_BITS-1:0]     m;
   } mix_type;

endpackage
`default_nettype wire

### hdl/hcy_tri.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcy_tri
// Stages 1-2: triangle weight from hue, then X = floor(C * weight / 2^N).
// ----------------------------------------------------------------------------
module hcy_tri (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire hcy_pkg::req_type in_data,
   output hcy_pkg::tri_type      tri_out
);

   localparam int CB = hcy_pkg::CHANNEL_BITS;
   localparam int LS = hcy_pkg::LEVEL_S_BITS;
   localparam logic [CB-1:0] MAX_L = CB'(hcy_pkg::LEVEL_MAX);

   logic [CB:0]                    pos;
   logic [CB:0]                    delta;
   logic signed [LS-1:0]           s1_w_in;
   logic                           s1_valid_ff;
   logic [hcy_pkg::SEXT_BITS-1:0]  s1_sext_ff;
   logic [CB-1:0]                  s1_chroma_ff;
   logic [CB-1:0]                  s1_luma_ff;
   logic signed [LS-1:0]           s1_w_ff;
   logic signed [2*LS-1:0]         prod;
   hcy_pkg::tri_type               tri_in;
   hcy_pkg::tri_type               tri_ff;

   // stage 1: weight = MAX - |pos - MAX|, -1 at the top edge
   always_comb begin
      pos = in_data.hue[CB:0];
      if (pos >= {1'b0, MAX_L}) begin
         delta = pos - {1'b0, MAX_L};
      end else begin
         delta = {1'b0, MAX_L} - pos;
      end
      s1_w_in = LS'($signed({2'b00, MAX_L}) - $signed({1'b0, delta}));
   end

   always_ff @(posedge clock) begin
      s1_sext_ff   <= in_data.hue[hcy_pkg::HUE_BITS-1:CB];
      s1_chroma_ff <= in_data.chroma;
      s1_luma_ff   <= in_data.luma;
      s1_w_ff      <= s1_w_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   // stage 2: signed multiply, arithmetic shift floors
   always_comb begin
      prod           = $signed({1'b0, s1_chroma_ff}) * s1_w_ff;
      tri_in.valid   = s1_valid_ff & ~reset;
      tri_in.sextant = s1_sext_ff;
      tri_in.chroma  = s1_chroma_ff;
      tri_in.luma    = s1_luma_ff;
      tri_in.x       = LS'(prod >>> CB);
   end

   always_ff @(posedge clock) begin
      tri_ff <= tri_in;
   end

   assign tri_out = tri_ff;

endmodule
`default_nettype wire

### hdl/hcy_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcy_mix
// Stages 3-4: sextant routing, weighted luma of the pure color, luma offset.
// ----------------------------------------------------------------------------
module hcy_mix (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire hcy_pkg::tri_type tri_in,
   output hcy_pkg::mix_type      mix_out
);

   localparam int CB = hcy_pkg::CHANNEL_BITS;
   localparam int LS = hcy_pkg::LEVEL_S_BITS;
   localparam int PB = hcy_pkg::PROD_BITS;
   localparam int SB = hcy_pkg::SUM_BITS;

   logic signed [LS-1:0] c_s;
   logic signed [LS-1:0] r_in;
   logic signed [LS-1:0] g_in;
   logic signed [LS-1:0] b_in;
   logic signed [PB-1:0] pr_in;
   logic signed [PB-1:0] pg_in;
   logic signed [PB-1:0] pb_in;
   logic                 s3_valid_ff;
   logic signed [LS-1:0] s3_r_ff;
   logic signed [LS-1:0] s3_g_ff;
   logic signed [LS-1:0] s3_b_ff;
   logic signed [PB-1:0] s3_pr_ff;
   logic signed [PB-1:0] s3_pg_ff;
   logic signed [PB-1:0] s3_pb_ff;
   logic [CB-1:0]        s3_luma_ff;
   logic signed [SB-1:0] sum_in;
   hcy_pkg::mix_type     mix_in;
   hcy_pkg::mix_type     mix_ff;

   // stage 3: channel routing and constant weights
   always_comb begin
      c_s = $signed({1'b0, tri_in.chroma});
      case (tri_in.sextant)
         hcy_pkg::SEXT_RED_YEL: begin
            r_in = c_s;        g_in = tri_in.x;   b_in = '0;
         end
         hcy_pkg::SEXT_YEL_GRN: begin
            r_in = tri_in.x;   g_in = c_s;        b_in = '0;
         end
         hcy_pkg::SEXT_GRN_CYN: begin
            r_in = '0;         g_in = c_s;        b_in = tri_in.x;
         end
         hcy_pkg::SEXT_CYN_BLU: begin
            r_in = '0;         g_in = tri_in.x;   b_in = c_s;
         end
         hcy_pkg::SEXT_BLU_MAG: begin
            r_in = tri_in.x;   g_in = '0;         b_in = c_s;
         end
         hcy_pkg::SEXT_MAG_RED: begin
            r_in = c_s;        g_in = '0;         b_in = tri_in.x;
         end
         default: begin
            r_in = '0;         g_in = '0;         b_in = '0;
         end
      endcase
      pr_in = r_in * hcy_pkg::W_RED;
      pg_in = g_in * hcy_pkg::W_GREEN;
      pb_in = b_in * hcy_pkg::W_BLUE;
   end

   always_ff @(posedge clock) begin
      s3_r_ff    <= r_in;
      s3_g_ff    <= g_in;
      s3_b_ff    <= b_in;
      s3_pr_ff   <= pr_in;
      s3_pg_ff   <= pg_in;
      s3_pb_ff   <= pb_in;
      s3_luma_ff <= tri_in.luma;
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= tri_in.valid;
      end
   end

   // stage 4: m = luma - floor(weighted sum / 4096)
   always_comb begin
      sum_in = SB'(s3_pr_ff) + SB'(s3_pg_ff) + SB'(s3_pb_ff);
      mix_in.valid = s3_valid_ff & ~reset;
      mix_in.r     = s3_r_ff;
      mix_in.g     = s3_g_ff;
      mix_in.b     = s3_b_ff;
      mix_in.m     = hcy_pkg::OFS_BITS'($signed({1'b0, s3_luma_ff})
                        - (sum_in >>> hcy_pkg::WEIGHT_SHIFT));
   end

   always_ff @(posedge clock) begin
      mix_ff <= mix_in;
   end

   assign mix_out = mix_ff;

endmodule
`default_nettype wire

### hdl/hcy_clamp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcy_clamp
// Stage 5: add luma offset to each channel and clamp to 0..MAX.
// ----------------------------------------------------------------------------
module hcy_clamp (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire hcy_pkg::mix_type mix_in,
   output logic                 out_valid,
   output hcy_pkg::rsp_type      out_data
);

   localparam int CB = hcy_pkg::CHANNEL_BITS;
   localparam int MB = hcy_pkg::MIX_BITS;

   function automatic logic [CB-1:0] clamp_level(input logic signed [MB-1:0] v);
      logic [CB-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > $signed(MB'(hcy_pkg::LEVEL_MAX))) begin
         res = CB'(hcy_pkg::LEVEL_MAX);
      end else begin
         res = v[CB-1:0];
      end
      return res;
   endfunction

   logic signed [MB-1:0] m_ext;
   hcy_pkg::rsp_type     out_in;
   hcy_pkg::rsp_type     out_ff;
   logic                 valid_ff;

   always_comb begin
      m_ext        = MB'(mix_in.m);
      out_in.red   = clamp_level(MB'(mix_in.r) + m_ext);
      out_in.green = clamp_level(MB'(mix_in.g) + m_ext);
      out_in.blue  = clamp_level(MB'(mix_in.b) + m_ext);
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= mix_in.valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = out_ff;

endmodule
`default_nettype wire

### hdl/hcy_to_rgb_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcy_to_rgb_converter
// rsp_valid follows start through s1_valid_ff, tri_ff, s3_valid_ff, mix_ff and valid_ff.
// Throughput: one transaction per clock; busy is always low, five stages.
// The receiver cannot stall; every result is presented for one cycle.
// Reset (synchronous) clears all stage valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module hcy_to_rgb_converter (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire hcy_pkg::req_type req_data,
   output logic                 rsp_valid,
   output hcy_pkg::rsp_type      rsp_data
);

   logic             in_valid;
   hcy_pkg::tri_type tri_bus;
   hcy_pkg::mix_type mix_bus;

   assign busy     = 1'b0;
   assign in_valid = start & ~busy;

   hcy_tri u_tri (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_data  (req_data),
      .tri_out  (tri_bus)
   );

   hcy_mix u_mix (
      .clock   (clock),
      .reset   (reset),
      .tri_in  (tri_bus),
      .mix_out (mix_bus)
   );

   hcy_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .mix_in    (mix_bus),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule
`default_nettype wire

### hdl/hcy_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcy_checker
// Port-level checks: fixed latency, no lost or extra transactions, grey path.
// ----------------------------------------------------------------------------
module hcy_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire hcy_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire hcy_pkg::rsp_type rsp_data
);

   localparam int HB = hcy_pkg::HUE_BITS;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy asserted");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 5))
      else $error("result without matching transaction");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      ($past(start, 5) && !$past(reset, 5) && !$past(reset, 4) && !$past(reset, 3)
       && !$past(reset, 2) && !$past(reset, 1)) |-> rsp_valid)
      else $error("transaction lost");

   a_grey: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_data.chroma, 5) == '0
                     || $past(req_data.hue[HB-1:HB-2], 5) == 2'b11))
      |-> (rsp_data.red == $past(req_data.luma, 5)
           && rsp_data.green == $past(req_data.luma, 5)
           && rsp_data.blue == $past(req_data.luma, 5)))
      else $error("grey result differs from luma");

endmodule

bind hcy_to_rgb_converter hcy_checker u_hcy_checker (.*);
`default_nettype wire

### tb/sv/hcy_rgb_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcy_rgb_monitor
// Watches the request and response channels of the HCY to RGB converter,
// computes the expected clamped RGB color for every accepted transaction and
// compares each response field by field against the oldest expected color.
// ----------------------------------------------------------------------------
module hcy_rgb_monitor (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  hcy_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  hcy_pkg::rsp_type rsp_data,
   output int               failures,
   output int               pending
);

   hcy_pkg::rsp_type expected_rgb[$];

   function automatic logic [hcy_pkg::CHANNEL_BITS-1:0] clamp_level(input int level);
      if (level < 0) begin
         return '0;
      end
      if (level > hcy_pkg::LEVEL_MAX) begin
         return hcy_pkg::CHANNEL_BITS'(hcy_pkg::LEVEL_MAX);
      end
      return hcy_pkg::CHANNEL_BITS'(level);
   endfunction

   function automatic hcy_pkg::rsp_type predict_rgb(input hcy_pkg::req_type item);
      int c;
      int luma;
      int pos;
      int delta;
      int x;
      int r;
      int g;
      int b;
      int m;
      logic [hcy_pkg::SEXT_BITS-1:0] sextant;
      hcy_pkg::rsp_type rgb;
      c       = int'(item.chroma);
      luma    = int'(item.luma);
      sextant = item.hue[hcy_pkg::HUE_BITS-1 -: hcy_pkg::SEXT_BITS];
      pos     = int'(item.hue[hcy_pkg::CHANNEL_BITS:0]);
      delta   = pos - hcy_pkg::LEVEL_MAX;
      if (delta < 0) begin
         delta = -delta;
      end
      // weight is -1 at the top of an odd sextant; >>> floors
      x = (c * (hcy_pkg::LEVEL_MAX - delta)) >>> hcy_pkg::CHANNEL_BITS;
      case (sextant)
         hcy_pkg::SEXT_RED_YEL: begin r = c; g = x; b = 0; end
         hcy_pkg::SEXT_YEL_GRN: begin r = x; g = c; b = 0; end
         hcy_pkg::SEXT_GRN_CYN: begin r = 0; g = c; b = x; end
         hcy_pkg::SEXT_CYN_BLU: begin r = 0; g = x; b = c; end
         hcy_pkg::SEXT_BLU_MAG: begin r = x; g = 0; b = c; end
         hcy_pkg::SEXT_MAG_RED: begin r = c; g = 0; b = x; end
         default: begin r = 0; g = 0; b = 0; end
      endcase
      m = luma - ((r * int'(hcy_pkg::W_RED) + g * int'(hcy_pkg::W_GREEN)
                   + b * int'(hcy_pkg::W_BLUE)) >>> hcy_pkg::WEIGHT_SHIFT);
      rgb.red   = clamp_level(r + m);
      rgb.green = clamp_level(g + m);
      rgb.blue  = clamp_level(b + m);
      return rgb;
   endfunction

   always @(posedge clock) begin : compare_rgb
      hcy_pkg::rsp_type want;
      int               errs;
      errs = 0;
      if (reset) begin
         expected_rgb.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_rgb.size() == 0) begin
               $error("unexpected response: red %0d green %0d blue %0d",
                      rsp_data.red, rsp_data.green, rsp_data.blue);
               errs++;
            end else begin
               want = expected_rgb.pop_front();
               if (rsp_data.red !== want.red) begin
                  $error("red mismatch: expected %0d, actual %0d", want.red, rsp_data.red);
                  errs++;
               end
               if (rsp_data.green !== want.green) begin
                  $error("green mismatch: expected %0d, actual %0d",
                         want.green, rsp_data.green);
                  errs++;
               end
               if (rsp_data.blue !== want.blue) begin
                  $error("blue mismatch: expected %0d, actual %0d", want.blue, rsp_data.blue);
                  errs++;
               end
            end
         end
         if (start && !busy) begin
            expected_rgb.push_back(predict_rgb(req_data));
         end
      end
      failures <= failures + errs;
      pending  <= expected_rgb.size();
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives HCY colors into the converter: directed extremes, every sextant,
// odd-sextant edges and out-of-range hues, then random colors with and
// without random idle cycles. Checking is done by hcy_rgb_monitor; this
// module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT  = 50000;
   localparam int RANDOM_ITEMS = 500;
   localparam int DRAIN_CYCLES = 12;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   hcy_pkg::req_type req_data;
   logic             rsp_valid;
   hcy_pkg::rsp_type rsp_data;
   int               failures;
   int               pending;
   int               idle_pct;
   int               sent = 0;
   int               cycles = 0;

   always #5 clock = ~clock;

   hcy_to_rgb_converter dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   hcy_rgb_monitor rgb_monitor (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_color(input hcy_pkg::req_type item);
      logic stalled;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do begin
         @(posedge clock);
         stalled = busy;
         @(negedge clock);
      end while (stalled);
      sent++;
   endtask

   task automatic send_hcy(input int hue, input int chroma, input int luma);
      hcy_pkg::req_type item;
      item.hue    = hcy_pkg::HUE_BITS'(hue);
      item.chroma = hcy_pkg::CHANNEL_BITS'(chroma);
      item.luma   = hcy_pkg::CHANNEL_BITS'(luma);
      send_color(item);
   endtask

   function automatic hcy_pkg::req_type random_color();
      hcy_pkg::req_type item;
      int               pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         item.hue = hcy_pkg::HUE_BITS'($urandom_range(32767, 24576));
      end else if (pick < 18) begin
         item.hue = hcy_pkg::HUE_BITS'((2 * $urandom_range(2) + 1) * 4096 + 4095);
      end else if (pick < 24) begin
         item.hue = hcy_pkg::HUE_BITS'($urandom_range(5) * 4096);
      end else begin
         item.hue = hcy_pkg::HUE_BITS'($urandom_range(24575));
      end
      pick = $urandom_range(99);
      item.chroma = (pick < 10) ? '0 : (pick < 20) ? '1 :
                    hcy_pkg::CHANNEL_BITS'($urandom_range(4095));
      pick = $urandom_range(99);
      item.luma = (pick < 10) ? '0 : (pick < 20) ? '1 :
                  hcy_pkg::CHANNEL_BITS'($urandom_range(4095));
      return item;
   endfunction

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      idle_pct = 9;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      send_hcy(0, 0, 0);
      send_hcy(0, 4095, 4095);
      send_hcy(4095, 4095, 2048);
      send_hcy(4096, 3000, 1000);
      send_hcy(8191, 4095, 2048);
      send_hcy(8191, 0, 100);
      send_hcy(16383, 1, 4095);
      send_hcy(24575, 4095, 0);
      for (int k = 0; k < 8; k++) begin
         send_hcy(k * 4096 + 2048, 4095, 2048);
      end
      send_hcy(12288, 4095, 0);
      send_hcy(20480, 4095, 4095);
      send_hcy(24576, 4095, 1234);
      send_hcy(28672, 2000, 0);
      send_hcy(32767, 4095, 4095);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 150) begin
            idle_pct = 0;
         end
         if (i == 300) begin
            idle_pct = 9;
         end
         if (i == 250) begin
            start <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
         send_color(random_color());
      end
      start <= 1'b0;

      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d transactions: extreme fields, all sextants, odd-sextant edges,", sent);
      $display("out-of-range hues and random colors, with and without idle cycles");
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
